[hdl/mld_pkg.sv]
// Shared types, sizes and the winner-selection rule for majority label downsampling.
// Has no dependencies; mld_reduce and majority_label_downsample import it.
`default_nettype none

package mld_pkg;

  localparam int LABEL_BITS   = 8;
  localparam int BLOCK_VOXELS = 8;
  localparam int CNT_BITS     = $clog2(BLOCK_VOXELS + 1);

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [CNT_BITS-1:0]   count_t;

  // Control that travels with each request through the pipeline.
  typedef struct packed {
    logic valid;
    logic prefer_larger;
  } ctl_t;

  // True when candidate b beats candidate a: a higher count wins; on equal
  // counts the tie-break mode decides by label value.
  function automatic logic b_wins(input count_t ca, input label_t la,
                                  input count_t cb, input label_t lb,
                                  input logic prefer_larger);
    logic tie_win;
    tie_win = prefer_larger ? (lb > la) : (lb < la);
    return (cb > ca) || ((cb == ca) && tie_win);
  endfunction

endpackage

`default_nettype wire

[hdl/mld_reduce.sv]
// Two-stage registered selection tree that picks the winning label of a block.
// Depends on mld_pkg for types and the b_wins rule.
`default_nettype none

module mld_reduce
  import mld_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  count_t cnt_i   [BLOCK_VOXELS],
  input  label_t label_i [BLOCK_VOXELS],
  output ctl_t   ctl_o,
  output label_t label_o
);

  localparam int HALF = BLOCK_VOXELS / 2;

  ctl_t   ctl_mid_q;
  count_t cnt_mid_d   [HALF];
  label_t label_mid_d [HALF];
  count_t cnt_mid_q   [HALF];
  label_t label_mid_q [HALF];

  ctl_t   ctl_out_q;
  label_t label_out_d;
  label_t label_out_q;

  // First level: eight candidates down to four.
  always_comb begin
    for (int k = 0; k < HALF; k++) begin
      if (b_wins(cnt_i[2*k], label_i[2*k], cnt_i[2*k+1], label_i[2*k+1],
                 ctl_i.prefer_larger)) begin
        cnt_mid_d[k]   = cnt_i[2*k+1];
        label_mid_d[k] = label_i[2*k+1];
      end else begin
        cnt_mid_d[k]   = cnt_i[2*k];
        label_mid_d[k] = label_i[2*k];
      end
    end
  end

  // Second and third levels: four down to two down to one.
  always_comb begin
    count_t c0;
    count_t c1;
    label_t l0;
    label_t l1;
    c0 = cnt_mid_q[0];
    l0 = label_mid_q[0];
    if (b_wins(cnt_mid_q[0], label_mid_q[0], cnt_mid_q[1], label_mid_q[1],
               ctl_mid_q.prefer_larger)) begin
      c0 = cnt_mid_q[1];
      l0 = label_mid_q[1];
    end
    c1 = cnt_mid_q[2];
    l1 = label_mid_q[2];
    if (b_wins(cnt_mid_q[2], label_mid_q[2], cnt_mid_q[3], label_mid_q[3],
               ctl_mid_q.prefer_larger)) begin
      c1 = cnt_mid_q[3];
      l1 = label_mid_q[3];
    end
    label_out_d = b_wins(c0, l0, c1, l1, ctl_mid_q.prefer_larger) ? l1 : l0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_mid_q <= '0;
      ctl_out_q <= '0;
    end else begin
      ctl_mid_q <= ctl_i;
      ctl_out_q <= ctl_mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_mid_q   <= cnt_mid_d;
    label_mid_q <= label_mid_d;
    label_out_q <= label_out_d;
  end

  assign ctl_o   = ctl_out_q;
  assign label_o = label_out_q;

endmodule

`default_nettype wire

[hdl/majority_label_downsample.sv]
// Top level of the 2x2x2 majority (mode) label downsampler.
// Depends on mld_pkg and instantiates mld_reduce.
`default_nettype none

// Majority label downsampler. A request carries the eight labels of one
// 2x2x2 voxel block; the block returns the label that occurs most often
// among them. When several labels share the highest count, the tie-break
// register selects the smallest tied label (0, the reset value) or the
// largest (1). The design is a four-stage pipeline: input capture, per-voxel
// occurrence counts, a first selection level, and a final selection level
// that drives the result register. A request is taken whenever start is
// high; busy is always low, so one block can be issued every clock cycle.
// Each result appears on majority_label_o with done_o high for exactly one
// cycle, once its request has passed the capture, count and both selection
// registers; results come out in request order. The receiver cannot stall
// the block. The tie-break mode is sampled together with each request, and
// should be written only while no request is in flight.
module majority_label_downsample
  import mld_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  label_t label_a_i,
  input  label_t label_b_i,
  input  label_t label_c_i,
  input  label_t label_d_i,
  input  label_t label_e_i,
  input  label_t label_f_i,
  input  label_t label_g_i,
  input  label_t label_h_i,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  output logic   done_o,
  output label_t majority_label_o
);

  // Tie-break configuration register.
  logic prefer_larger_q;

  // Stage 1: captured request.
  ctl_t   ctl_s1_q;
  label_t label_s1_q [BLOCK_VOXELS];

  // Stage 2: how often each voxel's label occurs within the block.
  ctl_t   ctl_s2_q;
  count_t cnt_s2_d   [BLOCK_VOXELS];
  count_t cnt_s2_q   [BLOCK_VOXELS];
  label_t label_s2_q [BLOCK_VOXELS];

  ctl_t   ctl_out;

  // The pipeline never stalls, so a request is always taken.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefer_larger_q <= 1'b0;
    end else if (cfg_we_i) begin
      prefer_larger_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s1_q <= '0;
      ctl_s2_q <= '0;
    end else begin
      ctl_s1_q.valid         <= start;
      ctl_s1_q.prefer_larger <= prefer_larger_q;
      ctl_s2_q               <= ctl_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    label_s1_q[0] <= label_a_i;
    label_s1_q[1] <= label_b_i;
    label_s1_q[2] <= label_c_i;
    label_s1_q[3] <= label_d_i;
    label_s1_q[4] <= label_e_i;
    label_s1_q[5] <= label_f_i;
    label_s1_q[6] <= label_g_i;
    label_s1_q[7] <= label_h_i;
  end

  // Each voxel is compared with all eight (itself included), so every count
  // is at least one. Voxels that share a label get identical counts, which
  // lets the selection tree treat them as equal candidates.
  always_comb begin
    for (int i = 0; i < BLOCK_VOXELS; i++) begin
      cnt_s2_d[i] = '0;
      for (int j = 0; j < BLOCK_VOXELS; j++) begin
        cnt_s2_d[i] = cnt_s2_d[i] + count_t'(label_s1_q[j] == label_s1_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_s2_q   <= cnt_s2_d;
    label_s2_q <= label_s1_q;
  end

  // Stages 3 and 4: pick the candidate with the highest count, ties broken
  // by label value according to the mode carried with the request.
  mld_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_s2_q),
    .cnt_i   (cnt_s2_q),
    .label_i (label_s2_q),
    .ctl_o   (ctl_out),
    .label_o (majority_label_o)
  );

  assign done_o = ctl_out.valid;

  // A result strobe only follows a matching earlier request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4))
    else $error("result strobe without matching request");

  // The chosen label is always one of the block's own labels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (majority_label_o == $past(label_a_i, 4) ||
                majority_label_o == $past(label_b_i, 4) ||
                majority_label_o == $past(label_c_i, 4) ||
                majority_label_o == $past(label_d_i, 4) ||
                majority_label_o == $past(label_e_i, 4) ||
                majority_label_o == $past(label_f_i, 4) ||
                majority_label_o == $past(label_g_i, 4) ||
                majority_label_o == $past(label_h_i, 4)))
    else $error("result label not present in its block");

  // After four requests in a row, the last of them still produces its strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && $past(start) && $past(start, 2) && $past(start, 3) &&
     $past(rst_ni, 4)) |=> ##3 done_o)
    else $error("result strobe lost in back-to-back stream");

endmodule

`default_nettype wire
